>>> hw/rtl/lhm_pkg.sv
// Shared types and constants of the link heartbeat health monitor.
`default_nettype none

package lhm_pkg;

    // Widths fixed by the item and result formats
    localparam int TIME_W     = 48;
    localparam int LINK_W     = 4;
    localparam int DROP_W     = 16;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 1;

    // Configuration reset values
    localparam logic [CFG_DATA_W-1:0] FRAME_TIMEOUT_RST = 32'd1500;
    localparam logic [CFG_DATA_W-1:0] BEAT_TIMEOUT_RST  = 32'd3000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TIMEOUT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BEAT_TIMEOUT  = 1'd1;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_FRAME  = 2'd1,
        CMD_BEAT   = 2'd2,
        CMD_UNUSED = 2'd3
    } lhm_cmd_t;

    typedef enum logic [1:0] {
        RSN_NONE          = 2'd0,
        RSN_NEVER_SEEN    = 2'd1,
        RSN_FRAME_TIMEOUT = 2'd2,
        RSN_BEAT_STALE    = 2'd3
    } lhm_reason_t;

    typedef struct packed {
        lhm_cmd_t            cmd;
        logic [LINK_W-1:0]   link_sel;
        logic [TIME_W-1:0]   now_ms;
    } lhm_item_t;

    typedef struct packed {
        logic [LINK_W-1:0]   link_id;
        logic                is_final;
        logic                link_up;
        lhm_reason_t         down_reason;
        logic                frames_fresh;
        logic                beat_fresh;
        logic [TIME_W-1:0]   frame_age_ms;
        logic [TIME_W-1:0]   beat_age_ms;
        logic [DROP_W-1:0]   drop_count;
        logic                state_changed;
        logic [TIME_W-1:0]   change_time_ms;
        logic [TIME_W-1:0]   drop_time_ms;
    } lhm_result_t;

endpackage

`default_nettype wire

>>> hw/rtl/link_heartbeat_health_monitor.sv
// Top level of the link heartbeat health monitor: link records, sequencer and age unit.
`default_nettype none

// Frame and heartbeat items are taken while idle and leave busy low.
// A tick item raises busy and walks links 0..NUM_LINKS-1; each link passes
// through a frame age step and a heartbeat age step on the shared
// subtract-and-compare unit and then a record update step. Busy stays high
// until the last link's update, and result_valid pulses once per link,
// registered from that link's update. Results cannot be held off: each one is
// on the result port for exactly one cycle. Times are kept modulo
// 2^min(TIME_BITS,48); a stored time of zero means never.
module link_heartbeat_health_monitor
    import lhm_pkg::*;
#(
    parameter int NUM_LINKS = 2,
    parameter int TIME_BITS = 48
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire lhm_item_t             item,
    output logic                       result_valid,
    output lhm_result_t                result,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int TW    = (TIME_BITS < TIME_W) ? TIME_BITS : TIME_W;
    localparam int IDX_W = (NUM_LINKS > 1) ? $clog2(NUM_LINKS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_LINKS - 1);
    localparam logic [LINK_W:0]  LINK_CNT = (LINK_W + 1)'(NUM_LINKS);
    localparam logic [DROP_W-1:0] DROP_MAX = '1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_FRAME = 4'b0010,
        ST_BEAT  = 4'b0100,
        ST_EMIT  = 4'b1000
    } lhm_state_t;

    lhm_state_t state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [TW-1:0]    now_reg;

    logic [CFG_DATA_W-1:0] frame_timeout_reg;
    logic [CFG_DATA_W-1:0] beat_timeout_reg;

    // Per-link records
    logic [TW-1:0]     frame_time_reg  [NUM_LINKS];
    logic              link_seen_reg   [NUM_LINKS];
    logic [TW-1:0]     beat_time_reg   [NUM_LINKS];
    logic              beat_seen_reg   [NUM_LINKS];
    logic              up_flag_reg     [NUM_LINKS];
    logic [DROP_W-1:0] drops_reg       [NUM_LINKS];
    logic [TW-1:0]     change_time_reg [NUM_LINKS];
    logic [TW-1:0]     drop_time_reg   [NUM_LINKS];

    // Ages and freshness of the link under evaluation
    logic [TW-1:0] frame_age_reg;
    logic          frames_fresh_reg;
    logic [TW-1:0] beat_age_reg;
    logic          beat_fresh_reg;

    logic        result_valid_reg;
    lhm_result_t result_reg;

    logic accept;
    logic sel_ok;
    logic [IDX_W-1:0] sel_idx;

    // Shared age unit signals
    logic [TW-1:0]         unit_last;
    logic [CFG_DATA_W-1:0] unit_limit;
    logic                  unit_seen;
    logic [TW:0]           unit_diff;
    logic                  unit_never;
    logic                  unit_late;
    logic [TW-1:0]         unit_age;
    logic                  unit_fresh;

    // Record update signals
    logic          cur_seen;
    logic          cur_old_up;
    logic          cur_up;
    lhm_reason_t   cur_reason;
    logic          cur_changed;
    logic          cur_drop;
    logic [DROP_W-1:0] drops_next;
    logic [TW-1:0]     change_time_next;
    logic [TW-1:0]     drop_time_next;

    assign busy         = (state_reg != ST_IDLE);
    assign accept       = start && !busy;
    assign sel_ok       = ({1'b0, item.link_sel} < LINK_CNT);
    assign sel_idx      = item.link_sel[IDX_W-1:0];
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Shared unit: age = now - last, fresh when seen, nonzero, not late, within limit
    always_comb
    begin
        if (state_reg == ST_BEAT)
        begin
            unit_last  = beat_time_reg[idx_reg];
            unit_limit = beat_timeout_reg;
            unit_seen  = beat_seen_reg[idx_reg];
        end
        else
        begin
            unit_last  = frame_time_reg[idx_reg];
            unit_limit = frame_timeout_reg;
            unit_seen  = link_seen_reg[idx_reg];
        end
        unit_diff  = {1'b0, now_reg} - {1'b0, unit_last};
        unit_never = (unit_last == '0);
        unit_late  = unit_diff[TW];
        unit_age   = (unit_never || unit_late) ? '0 : unit_diff[TW-1:0];
        unit_fresh = unit_seen && !unit_never && !unit_late
                     && (unit_diff[TW-1:0] <= TW'(unit_limit));
    end

    // Decide online state and next record values for the current link
    always_comb
    begin
        cur_seen   = link_seen_reg[idx_reg];
        cur_old_up = up_flag_reg[idx_reg];
        cur_up     = 1'b0;
        if (!cur_seen)
        begin
            cur_reason = RSN_NEVER_SEEN;
        end
        else if (!frames_fresh_reg)
        begin
            cur_reason = RSN_FRAME_TIMEOUT;
        end
        else if (!beat_fresh_reg)
        begin
            cur_reason = RSN_BEAT_STALE;
        end
        else
        begin
            cur_reason = RSN_NONE;
            cur_up     = 1'b1;
        end
        cur_changed      = (cur_up != cur_old_up);
        cur_drop         = cur_changed && !cur_up;
        drops_next       = drops_reg[idx_reg];
        change_time_next = change_time_reg[idx_reg];
        drop_time_next   = drop_time_reg[idx_reg];
        if (cur_changed)
        begin
            change_time_next = now_reg;
        end
        if (cur_drop)
        begin
            drop_time_next = now_reg;
            if (drops_reg[idx_reg] != DROP_MAX)
            begin
                drops_next = drops_reg[idx_reg] + 1'b1;
            end
        end
    end

    // Sequencer: one link per FRAME, BEAT, EMIT pass
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && item.cmd == CMD_TICK)
                begin
                    state_next = ST_FRAME;
                    idx_next   = '0;
                end
            end
            ST_FRAME:
            begin
                state_next = ST_BEAT;
            end
            ST_BEAT:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_FRAME;
                    idx_next   = idx_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Advance the sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            idx_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            idx_reg          <= idx_next;
            result_valid_reg <= (state_reg == ST_EMIT);
        end
    end

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_timeout_reg <= FRAME_TIMEOUT_RST;
            beat_timeout_reg  <= BEAT_TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FRAME_TIMEOUT: frame_timeout_reg <= cfg_data;
                CFG_BEAT_TIMEOUT:  beat_timeout_reg  <= cfg_data;
                default:           frame_timeout_reg <= frame_timeout_reg;
            endcase
        end
    end

    // Latch tick time and hold the unit outputs per pass
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            now_reg <= item.now_ms[TW-1:0];
        end
        if (state_reg == ST_FRAME)
        begin
            frame_age_reg    <= unit_age;
            frames_fresh_reg <= unit_fresh;
        end
        if (state_reg == ST_BEAT)
        begin
            beat_age_reg   <= unit_age;
            beat_fresh_reg <= unit_fresh;
        end
    end

    // Update link records on frame and heartbeat items and on each evaluation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LINKS; i++)
            begin
                frame_time_reg[i]  <= '0;
                link_seen_reg[i]   <= 1'b0;
                beat_time_reg[i]   <= '0;
                beat_seen_reg[i]   <= 1'b0;
                up_flag_reg[i]     <= 1'b0;
                drops_reg[i]       <= '0;
                change_time_reg[i] <= '0;
                drop_time_reg[i]   <= '0;
            end
        end
        else
        begin
            if (accept && sel_ok && item.cmd == CMD_FRAME)
            begin
                frame_time_reg[sel_idx] <= item.now_ms[TW-1:0];
                link_seen_reg[sel_idx]  <= 1'b1;
            end
            if (accept && sel_ok && item.cmd == CMD_BEAT)
            begin
                beat_time_reg[sel_idx] <= item.now_ms[TW-1:0];
                beat_seen_reg[sel_idx] <= 1'b1;
            end
            if (state_reg == ST_EMIT)
            begin
                up_flag_reg[idx_reg]     <= cur_up;
                drops_reg[idx_reg]       <= drops_next;
                change_time_reg[idx_reg] <= change_time_next;
                drop_time_reg[idx_reg]   <= drop_time_next;
            end
        end
    end

    // Build the result item
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EMIT)
        begin
            result_reg.link_id        <= LINK_W'(idx_reg);
            result_reg.is_final       <= (idx_reg == LAST_IDX);
            result_reg.link_up        <= cur_up;
            result_reg.down_reason    <= cur_reason;
            result_reg.frames_fresh   <= frames_fresh_reg;
            result_reg.beat_fresh     <= beat_fresh_reg;
            result_reg.frame_age_ms   <= TIME_W'(frame_age_reg);
            result_reg.beat_age_ms    <= TIME_W'(beat_age_reg);
            result_reg.drop_count     <= drops_next;
            result_reg.state_changed  <= cur_changed;
            result_reg.change_time_ms <= TIME_W'(change_time_next);
            result_reg.drop_time_ms   <= TIME_W'(drop_time_next);
        end
    end

    // A result follows only an evaluation pass
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg == ST_EMIT))
        else $error("result without evaluation pass");

    // The last link's result ends the tick
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.is_final) |-> !busy)
        else $error("busy after final result");

    // An accepted tick starts a walk
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.cmd == CMD_TICK) |=> busy)
        else $error("tick not started");

    // Online only with both records fresh and no reason
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.link_up) |->
            (result.frames_fresh && result.beat_fresh && result.down_reason == RSN_NONE))
        else $error("online link with stale record");

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench of the link heartbeat health monitor.
`timescale 1ns / 1ps

import lhm_pkg::*;

// Link records kept alongside the block; predicts the status of every link on a tick
class link_health_board #(int LINKS = 2);
    int errors;
    lhm_result_t pending_status[$];

    logic [CFG_DATA_W-1:0] frame_limit;
    logic [CFG_DATA_W-1:0] beat_limit;
    logic [TIME_W-1:0]     frame_time  [LINKS];
    logic                  link_seen   [LINKS];
    logic [TIME_W-1:0]     beat_time   [LINKS];
    logic                  beat_seen   [LINKS];
    logic                  link_online [LINKS];
    logic [DROP_W-1:0]     drops       [LINKS];
    logic [TIME_W-1:0]     change_time [LINKS];
    logic [TIME_W-1:0]     drop_time   [LINKS];

    function new();
        errors      = 0;
        frame_limit = FRAME_TIMEOUT_RST;
        beat_limit  = BEAT_TIMEOUT_RST;
        for (int i = 0; i < LINKS; i++)
        begin
            frame_time[i]  = '0;
            link_seen[i]   = 1'b0;
            beat_time[i]   = '0;
            beat_seen[i]   = 1'b0;
            link_online[i] = 1'b0;
            drops[i]       = '0;
            change_time[i] = '0;
            drop_time[i]   = '0;
        end
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        if (idx == CFG_FRAME_TIMEOUT)
            frame_limit = data;
        else if (idx == CFG_BEAT_TIMEOUT)
            beat_limit = data;
    endfunction

    // A stored time of zero or one later than now is never fresh
    function bit is_fresh(logic [TIME_W-1:0] now, logic [TIME_W-1:0] last,
                          logic [CFG_DATA_W-1:0] limit);
        if (last == '0 || now < last)
            return 1'b0;
        return (now - last) <= {{(TIME_W-CFG_DATA_W){1'b0}}, limit};
    endfunction

    function logic [TIME_W-1:0] age_of(logic [TIME_W-1:0] now, logic [TIME_W-1:0] last);
        if (last == '0 || now < last)
            return '0;
        return now - last;
    endfunction

    function int pending();
        return pending_status.size();
    endfunction

    // Update the records for one accepted item; a tick queues one status per link
    function void take_item(lhm_item_t it);
        lhm_result_t st;
        bit ff;
        bit bf;
        bit up;
        case (it.cmd)
            CMD_FRAME:
            begin
                if (it.link_sel < LINKS)
                begin
                    frame_time[it.link_sel] = it.now_ms;
                    link_seen[it.link_sel]  = 1'b1;
                end
            end
            CMD_BEAT:
            begin
                if (it.link_sel < LINKS)
                begin
                    beat_time[it.link_sel] = it.now_ms;
                    beat_seen[it.link_sel] = 1'b1;
                end
            end
            CMD_TICK:
            begin
                for (int i = 0; i < LINKS; i++)
                begin
                    ff = link_seen[i] && is_fresh(it.now_ms, frame_time[i], frame_limit);
                    bf = beat_seen[i] && is_fresh(it.now_ms, beat_time[i], beat_limit);
                    st = '0;
                    if (!link_seen[i])
                    begin
                        up = 1'b0;
                        st.down_reason = RSN_NEVER_SEEN;
                    end
                    else if (!ff)
                    begin
                        up = 1'b0;
                        st.down_reason = RSN_FRAME_TIMEOUT;
                    end
                    else if (!bf)
                    begin
                        up = 1'b0;
                        st.down_reason = RSN_BEAT_STALE;
                    end
                    else
                    begin
                        up = 1'b1;
                        st.down_reason = RSN_NONE;
                    end
                    st.state_changed = (up != link_online[i]);
                    if (st.state_changed)
                    begin
                        change_time[i] = it.now_ms;
                        if (!up)
                        begin
                            drop_time[i] = it.now_ms;
                            if (drops[i] != {DROP_W{1'b1}})
                                drops[i] = drops[i] + 1'b1;
                        end
                    end
                    link_online[i]    = up;
                    st.link_id        = i[LINK_W-1:0];
                    st.is_final       = (i == LINKS - 1);
                    st.link_up        = up;
                    st.frames_fresh   = ff;
                    st.beat_fresh     = bf;
                    st.frame_age_ms   = age_of(it.now_ms, frame_time[i]);
                    st.beat_age_ms    = age_of(it.now_ms, beat_time[i]);
                    st.drop_count     = drops[i];
                    st.change_time_ms = change_time[i];
                    st.drop_time_ms   = drop_time[i];
                    pending_status = {pending_status, st};
                end
            end
            default: ;
        endcase
    endfunction

    function void cmp(int link, string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t link %0d %s: expected %0h, actual %0h", $time, link, name, want, got);
        end
    endfunction

    // Compare one status from the block against the oldest prediction
    function void match_status(lhm_result_t got);
        lhm_result_t want;
        if (pending_status.size() == 0)
        begin
            errors++;
            $display("%0t unexpected status: expected none, actual link %0d", $time,
                     got.link_id);
            return;
        end
        want = pending_status.pop_front();
        cmp(want.link_id, "link_id",        want.link_id,        got.link_id);
        cmp(want.link_id, "is_final",       want.is_final,       got.is_final);
        cmp(want.link_id, "link_up",        want.link_up,        got.link_up);
        cmp(want.link_id, "down_reason",    want.down_reason,    got.down_reason);
        cmp(want.link_id, "frames_fresh",   want.frames_fresh,   got.frames_fresh);
        cmp(want.link_id, "beat_fresh",     want.beat_fresh,     got.beat_fresh);
        cmp(want.link_id, "frame_age_ms",   want.frame_age_ms,   got.frame_age_ms);
        cmp(want.link_id, "beat_age_ms",    want.beat_age_ms,    got.beat_age_ms);
        cmp(want.link_id, "drop_count",     want.drop_count,     got.drop_count);
        cmp(want.link_id, "state_changed",  want.state_changed,  got.state_changed);
        cmp(want.link_id, "change_time_ms", want.change_time_ms, got.change_time_ms);
        cmp(want.link_id, "drop_time_ms",   want.drop_time_ms,   got.drop_time_ms);
    endfunction

    // Fail every status that never arrived and drop it
    function void flush_missing();
        lhm_result_t want;
        while (pending_status.size() != 0)
        begin
            want = pending_status.pop_front();
            errors++;
            $display("%0t missing status: expected link %0d, actual none", $time,
                     want.link_id);
        end
    endfunction
endclass

module tb_top;

    localparam int NUM_LINKS   = 2;
    localparam int CYCLE_LIMIT = 5000000;
    localparam int SAT_PAIRS   = 4;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  start     = 1'b0;
    logic                  busy;
    lhm_item_t             item      = '0;
    logic                  result_valid;
    lhm_result_t           result;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    link_health_board #(NUM_LINKS) board;
    int                    idle_pct;
    int                    cycle_count = 0;
    logic [TIME_W-1:0]     wall_ms     = '0;

    link_heartbeat_health_monitor #(
        .NUM_LINKS (NUM_LINKS),
        .TIME_BITS (TIME_W)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Watch the ports: check each status, record each accepted item
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid)
                board.match_status(result);
            if (start && !busy)
                board.take_item(item);
        end
    end

    function automatic lhm_item_t mk(lhm_cmd_t cmd, int sel, logic [TIME_W-1:0] now);
        lhm_item_t it;
        it.cmd      = cmd;
        it.link_sel = sel[LINK_W-1:0];
        it.now_ms   = now;
        return it;
    endfunction

    // Present one item, hold it until taken, then idle at random
    task automatic send(lhm_item_t it);
        start <= 1'b1;
        item  <= it;
        do @(posedge clk); while (busy);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge clk);
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.set_reg(idx, data);
        @(posedge clk);
    endtask

    // Stop sending, wait for every predicted status, then let the block go quiet
    task automatic settle();
        int waited;
        waited = 0;
        start <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0 && waited < 200)
        begin
            @(posedge clk);
            waited++;
        end
        board.flush_missing();
        repeat (3 * NUM_LINKS + 4) @(posedge clk);
    endtask

    task automatic directed();
        // Nothing seen yet, then items the block must ignore
        send(mk(CMD_TICK, 0, 48'd0));
        send(mk(CMD_UNUSED, 0, 48'd7));
        send(mk(CMD_FRAME, 15, 48'd100));
        send(mk(CMD_BEAT, NUM_LINKS, 48'd100));
        // Frame stored at time zero: seen but never fresh
        send(mk(CMD_FRAME, 0, 48'd0));
        send(mk(CMD_TICK, 9, 48'd10));
        // Link 0 comes up, link 1 lacks a heartbeat
        send(mk(CMD_FRAME, 0, 48'd1000));
        send(mk(CMD_BEAT, 0, 48'd1000));
        send(mk(CMD_FRAME, 1, 48'd1000));
        send(mk(CMD_TICK, 0, 48'd2000));
        // Age equal to the timeout is still fresh, one more drops the link
        send(mk(CMD_TICK, 0, 48'd2500));
        send(mk(CMD_TICK, 0, 48'd2501));
        // Stored times later than now
        send(mk(CMD_TICK, 0, 48'd999));
        send(mk(CMD_BEAT, 1, 48'd4000));
        send(mk(CMD_FRAME, 0, 48'd4000));
        send(mk(CMD_BEAT, 0, 48'd4000));
        send(mk(CMD_FRAME, 1, 48'd4000));
        send(mk(CMD_TICK, 0, 48'd7000));
        // Fresh frame with a stale heartbeat
        send(mk(CMD_FRAME, 0, 48'd10000));
        send(mk(CMD_TICK, 0, 48'd10001));
        // Top of the time range
        send(mk(CMD_FRAME, 1, 48'hFFFF_FFFF_FFFF));
        send(mk(CMD_BEAT, 1, 48'hFFFF_FFFF_FFFF));
        send(mk(CMD_TICK, 0, 48'hFFFF_FFFF_FFFF));
        send(mk(CMD_TICK, 0, 48'd0));
    endtask

    // Mostly plausible traffic on a running clock, some noise and time jumps
    task automatic random_phase(int count);
        int useful;
        int pick;
        lhm_item_t it;
        logic [TIME_W-1:0] step;
        useful = 0;
        while (useful < count)
        begin
            pick = $urandom_range(99);
            if (pick < 85)
            begin
                pick = $urandom_range(99);
                if (pick < 25)
                    step = '0;
                else if (pick < 80)
                    step = TIME_W'($urandom_range(0, 2000));
                else if (pick < 95)
                    step = TIME_W'($urandom_range(0, 40000));
                else
                    step = TIME_W'({1'($urandom_range(0, 1)), $urandom});
                if ($urandom_range(99) < 5)
                    wall_ms = wall_ms - step;
                else
                    wall_ms = wall_ms + step;
                pick = $urandom_range(99);
                if (pick < 35)
                    it = mk(CMD_TICK, $urandom_range(0, 15), wall_ms);
                else if (pick < 70)
                    it = mk(CMD_FRAME, $urandom_range(0, NUM_LINKS - 1), wall_ms);
                else
                    it = mk(CMD_BEAT, $urandom_range(0, NUM_LINKS - 1), wall_ms);
            end
            else
            begin
                it.cmd      = lhm_cmd_t'($urandom_range(0, 3));
                it.link_sel = LINK_W'($urandom_range(0, 15));
                if ($urandom_range(3) == 0)
                    it.now_ms = '0;
                else
                    it.now_ms = {16'($urandom_range(0, 65535)), $urandom};
                if ($urandom_range(2) == 0)
                    wall_ms = it.now_ms;
            end
            if (it.cmd == CMD_TICK ||
                ((it.cmd == CMD_FRAME || it.cmd == CMD_BEAT) && it.link_sel < NUM_LINKS))
                useful++;
            send(it);
        end
    endtask

    // Toggle both links up and down a few times to move the drop counters
    task automatic toggle_links();
        for (int i = 0; i < NUM_LINKS; i++)
        begin
            send(mk(CMD_FRAME, i, 48'd5000));
            send(mk(CMD_BEAT, i, 48'd5000));
        end
        send(mk(CMD_TICK, 0, 48'd5000));
        for (int n = 0; n < SAT_PAIRS; n++)
        begin
            send(mk(CMD_TICK, 0, 48'd4999));
            send(mk(CMD_TICK, 0, 48'd5000));
        end
    endtask

    initial
    begin
        board = new();
        idle_pct = 25;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        directed();
        settle();
        write_reg(CFG_FRAME_TIMEOUT, $urandom_range(100, 5000));
        write_reg(CFG_BEAT_TIMEOUT, $urandom_range(100, 8000));
        random_phase(40);
        settle();

        write_reg(CFG_FRAME_TIMEOUT, '0);
        write_reg(CFG_BEAT_TIMEOUT, {CFG_DATA_W{1'b1}});
        idle_pct = 79;
        random_phase(40);
        settle();

        write_reg(CFG_FRAME_TIMEOUT, {CFG_DATA_W{1'b1}});
        write_reg(CFG_BEAT_TIMEOUT, '0);
        idle_pct = 0;
        random_phase(40);
        toggle_links();
        settle();

        if (board.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
